[src/fpts_pkg.sv]
// ----------------------------------------------------------------------------
// fpts_pkg
// Types and constants shared by the fixed-priority tick scheduler modules.
// ----------------------------------------------------------------------------
package fpts_pkg;

    localparam int SLOT_W    = 3;
    localparam int BUDGET_W  = 16;
    localparam int PERIOD_W  = 16;
    localparam int RUN_W     = 4;
    localparam int OP_W      = 1;
    localparam int S_FIELD_W = SLOT_W + BUDGET_W + PERIOD_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((RUN_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_TICK = 1'b1;

    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [BUDGET_W-1:0] t_budget;
    typedef logic [PERIOD_W-1:0] t_period;
    typedef logic [RUN_W-1:0]    t_run;

    typedef struct packed {
        logic    load;
        logic    tick;
        t_slot   slot;
        t_budget budget;
        t_period period;
    } t_cell_ctrl;

endpackage

[src/fpts_cell.sv]
// ----------------------------------------------------------------------------
// fpts_cell
// One task slot: budget, period and release countdown, with its link in the
// priority chain that carries the granted code on to lower-priority slots.
// ----------------------------------------------------------------------------
module fpts_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fpts_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_claim,
    input  fpts_pkg::t_run      i_code,
    output logic                o_claim,
    output fpts_pkg::t_run      o_code
);
    import fpts_pkg::*;

    localparam t_run CELL_CODE = RUN_W'(CELL_IDX + 1);

    t_budget r_rem, n_rem;
    t_budget r_job, n_job;
    t_period r_period, n_period;
    t_period r_count, n_count;

    logic    w_enabled;
    logic    w_eligible;
    logic    w_grant;
    t_budget w_rem_used;

    assign w_enabled  = (r_period != '0);
    assign w_eligible = w_enabled && (r_rem != '0);
    assign w_grant    = w_eligible && !i_claim;
    assign o_claim    = i_claim || w_eligible;
    assign o_code     = i_claim ? i_code : (w_eligible ? CELL_CODE : '0);
    assign w_rem_used = w_grant ? (r_rem - t_budget'(1)) : r_rem;

    always_comb begin
        n_rem    = r_rem;
        n_job    = r_job;
        n_period = r_period;
        n_count  = r_count;
        if (i_ctrl.load && (int'(i_ctrl.slot) == CELL_IDX)) begin
            n_rem    = i_ctrl.budget;
            n_job    = i_ctrl.budget;
            n_period = i_ctrl.period;
            n_count  = i_ctrl.period;
        end else if (i_ctrl.tick && w_enabled) begin
            n_rem = w_rem_used;
            if (r_count <= t_period'(1)) begin
                // release: reload countdown, refill only a finished job
                n_count = r_period;
                if (w_rem_used == '0) begin
                    n_rem = r_job;
                end
            end else begin
                n_count = r_count - t_period'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem    <= '0;
            r_job    <= '0;
            r_period <= '0;
            r_count  <= '0;
        end else begin
            r_rem    <= n_rem;
            r_job    <= n_job;
            r_period <= n_period;
            r_count  <= n_count;
        end
    end

endmodule

[src/fixed_priority_tick_scheduler.sv]
// ----------------------------------------------------------------------------
// fixed_priority_tick_scheduler
// Preemptive fixed-priority scheduler for periodic tasks, one tick a request.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while the output can take it: a load
// writes one slot's budget and period and returns nothing; a tick returns
// the granted slot plus one, or 0 when idle, from an output register in the
// next cycle. The rate is one request a cycle, set by the combinational grant
// chain through all TASK_SLOTS cells; a new request is taken while a result
// waits as long as the output register is being drained in the same cycle.
module fixed_priority_tick_scheduler #(
    parameter int TASK_SLOTS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // task_slot[2:0], exec_budget[18:3], task_period[34:19], zero pad
    input  logic [fpts_pkg::S_TDATA_W-1:0] i_s_tdata,
    // operation[0]
    input  logic [fpts_pkg::OP_W-1:0]      i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // running_task[3:0], zero pad
    output logic [fpts_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import fpts_pkg::*;

    logic       w_accept;
    t_cell_ctrl w_ctrl;
    logic       w_claim [TASK_SLOTS+1];
    t_run       w_code  [TASK_SLOTS+1];

    logic r_valid, n_valid;
    t_run r_run, n_run;

    assign o_s_tready = !r_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_ctrl.load   = w_accept && (i_s_tuser == OP_LOAD);
    assign w_ctrl.tick   = w_accept && (i_s_tuser == OP_TICK);
    assign w_ctrl.slot   = i_s_tdata[SLOT_W-1:0];
    assign w_ctrl.budget = i_s_tdata[SLOT_W +: BUDGET_W];
    assign w_ctrl.period = i_s_tdata[SLOT_W+BUDGET_W +: PERIOD_W];

    assign w_claim[0] = 1'b0;
    assign w_code[0]  = '0;

    for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
        fpts_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_claim (w_claim[g]),
            .i_code  (w_code[g]),
            .o_claim (w_claim[g+1]),
            .o_code  (w_code[g+1])
        );
    end

    always_comb begin
        n_valid = r_valid;
        n_run   = r_run;
        if (w_ctrl.tick) begin
            n_valid = 1'b1;
            n_run   = w_code[TASK_SLOTS];
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run <= n_run;
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(M_TDATA_W-RUN_W){1'b0}}, r_run};

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for fixed_priority_tick_scheduler.
// ----------------------------------------------------------------------------
// Sends task loads and time ticks over the request stream. A scoreboard class
// keeps its own copy of every slot's budget, period and release countdown. It
// predicts the slot granted on each tick and checks every returned result in
// order. A directed opening covers disabled slots, zero budgets, period-one
// slots and extreme field values. Random traffic follows: mostly ticks that
// carry noise in their data, mixed with loads with mostly short periods. The
// sender idles in bursts and the receiver stalls on its own pattern. The
// receiver also holds off for long stretches so that the block backs up.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fpts_pkg::*;

    localparam int TASK_SLOTS      = 8;
    localparam int LONG_HOLD       = 400;
    localparam int RANDOM_REQUESTS = 750;

    class grant_board;
        t_budget left_budget[TASK_SLOTS];
        t_budget job_budget[TASK_SLOTS];
        t_period period_len[TASK_SLOTS];
        t_period countdown[TASK_SLOTS];
        t_run    expected_grants[$];
        int      loads   = 0;
        int      ticks   = 0;
        int      granted = 0;
        int      idle    = 0;
        int      errors  = 0;

        function void clear();
            foreach (left_budget[i]) begin
                left_budget[i] = '0;
                job_budget[i]  = '0;
                period_len[i]  = '0;
                countdown[i]   = '0;
            end
            expected_grants.delete();
        endfunction

        function t_run predict_tick();
            t_run grant;
            bit   found;
            grant = '0;
            found = 1'b0;
            for (int i = 0; i < TASK_SLOTS; i++) begin
                if (!found && period_len[i] != 0 && left_budget[i] != 0) begin
                    left_budget[i] = left_budget[i] - 1'b1;
                    grant = t_run'(i + 1);
                    found = 1'b1;
                end
            end
            for (int i = 0; i < TASK_SLOTS; i++) begin
                if (period_len[i] != 0) begin
                    if (countdown[i] <= 1) begin
                        countdown[i] = period_len[i];
                        if (left_budget[i] == 0) begin
                            left_budget[i] = job_budget[i];
                        end
                    end else begin
                        countdown[i] = countdown[i] - 1'b1;
                    end
                end
            end
            return grant;
        endfunction

        function void note_request(logic [OP_W-1:0] op, t_slot s, t_budget b, t_period p);
            if (op == OP_LOAD) begin
                loads++;
                if (int'(s) < TASK_SLOTS) begin
                    job_budget[s]  = b;
                    left_budget[s] = b;
                    period_len[s]  = p;
                    countdown[s]   = p;
                end
            end else begin
                ticks++;
                expected_grants.push_back(predict_tick());
            end
        endfunction

        function void check_grant(logic [M_TDATA_W-1:0] data);
            t_run got;
            t_run want;
            got = data[RUN_W-1:0];
            if (expected_grants.size() == 0) begin
                $error("running_task: expected nothing, got %0d", got);
                errors++;
            end else begin
                want = expected_grants.pop_front();
                if (got !== want) begin
                    $error("running_task: expected %0d, got %0d", want, got);
                    errors++;
                end
                if (want == 0) begin
                    idle++;
                end else begin
                    granted++;
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    grant_board board;
    int         hold_ticket = 0;
    int         hold_seen   = 0;
    int         stall_left  = 0;
    int         rx_mode     = 0;
    int         rx_age      = 0;
    int         burst_left  = 0;

    fixed_priority_tick_scheduler #(
        .TASK_SLOTS (TASK_SLOTS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_ticket != hold_seen) begin
            hold_seen  = hold_ticket;
            stall_left = LONG_HOLD;
            m_tready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_age == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_age  = $urandom_range(20, 120);
            end
            rx_age--;
            case (rx_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= ($urandom_range(0, 3) != 0);
                end
                2: begin
                    m_tready <= ($urandom_range(0, 1) != 0);
                end
                default: begin
                    m_tready <= ((rx_age % 5) < 2);
                end
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            board.check_grant(m_tdata);
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input t_slot s,
                                input t_budget b, input t_period p);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({p, b, s});
        do @(posedge clk); while (!s_tready);
        board.note_request(op, s, b, p);
    endtask

    task automatic load_task(input t_slot s, input t_budget b, input t_period p);
        send_request(OP_LOAD, s, b, p);
    endtask

    task automatic tick_request();
        send_request(OP_TICK, t_slot'($urandom), t_budget'($urandom), t_period'($urandom));
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic pace_sender();
        if (burst_left == 0) begin
            idle_cycles(($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                    : $urandom_range(1, 6));
            burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 30);
        end
        burst_left--;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (board.expected_grants.size() != 0);
    endtask

    initial begin
        int      kind;
        t_budget b;
        t_period p;

        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_LOAD;
        rst_n    <= 1'b0;
        board = new;
        board.clear();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_TICK, '1, '1, '1);
        load_task(3'd7, 16'hFFFF, 16'hFFFF);
        load_task(3'd0, 16'd2, 16'd3);
        load_task(3'd3, 16'd0, 16'd2);
        load_task(3'd5, 16'd5, 16'd0);
        repeat (6) tick_request();
        load_task(3'd1, 16'd1, 16'd1);
        repeat (4) tick_request();
        load_task(3'd0, 16'd0, 16'd0);
        repeat (3) tick_request();
        load_task(3'd7, 16'd0, 16'd0);
        tick_request();
        wait_drained();

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == 150 || n == 550) begin
                hold_ticket <= hold_ticket + 1;
                burst_left = 80;
            end
            if (n == 350) begin
                wait_drained();
            end
            pace_sender();
            if ($urandom_range(0, 99) < 68) begin
                tick_request();
            end else begin
                kind = $urandom_range(0, 19);
                if (kind < 12) begin
                    b = t_budget'($urandom_range(1, 6));
                    p = t_period'($urandom_range(b, 24));
                end else if (kind < 14) begin
                    b = t_budget'($urandom);
                    p = t_period'($urandom);
                end else if (kind < 16) begin
                    b = t_budget'($urandom_range(1, 6));
                    p = '0;
                end else if (kind < 18) begin
                    b = '0;
                    p = t_period'($urandom_range(1, 24));
                end else begin
                    b = t_budget'($urandom_range(1, 3));
                    p = t_period'(1);
                end
                load_task(t_slot'($urandom), b, p);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        while (board.expected_grants.size() != 0) begin
            $error("running_task: expected %0d, got nothing",
                   board.expected_grants.pop_front());
            board.errors++;
        end

        $display("Run: %0d loads, %0d ticks (%0d granted, %0d idle) checked in order.",
                 board.loads, board.ticks, board.granted, board.idle);
        $display("Output held off for long stretches twice; input drained three times.");
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
src/fpts_pkg.sv
src/fpts_cell.sv
src/fixed_priority_tick_scheduler.sv
tb/tb.sv
